// ===== hw/rtl/ltcs_pkg.sv =====
// ----------------------------------------------------------------------------
// ltcs_pkg
// Shared types, constants and arithmetic helpers for the log-spaced
// cross-section lookup.
// ----------------------------------------------------------------------------
package ltcs_pkg;

   // table geometry
   localparam int TABLE_ENTRIES = 100;
   localparam int ADDR_W        = $clog2(TABLE_ENTRIES);

   // field widths
   localparam int IDX_W      = 7;
   localparam int VALUE_W    = 24;
   localparam int ENERGY_W   = 32;
   localparam int SCALE_W    = 24;
   localparam int XS_W       = 23;
   localparam int STATUS_W   = 2;
   localparam int CSR_DATA_W = 32;

   // log2 datapath widths
   localparam int MANT_W        = 32;                    // Q1.31 mantissa
   localparam int P_W           = 5;                     // leading-one position
   localparam int LOG_FRAC_BITS = 24;
   localparam int LOG_W         = P_W + LOG_FRAC_BITS;   // Q5.24
   localparam int D_W           = LOG_W + 1;             // signed difference
   localparam int LN_W          = LOG_W;                 // ln ratio, Q.24
   localparam int S_W           = LOG_W;                 // table position, Q.16
   localparam int FRAC_W        = 16;
   localparam int L_W           = S_W - FRAC_W;
   localparam int CNT_W         = $clog2(LOG_FRAC_BITS);

   // ln 2 in Q0.32
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   // register reset values
   localparam logic [SCALE_W-1:0]  LOG_SCALE_RESET   = 24'd687771;
   localparam logic [ENERGY_W-1:0] BASE_ENERGY_RESET = 32'd5243;

   typedef enum logic {
      ACTION_LOAD   = 1'b0,
      ACTION_LOOKUP = 1'b1
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_INTERP = 2'd0,
      STATUS_BELOW  = 2'd1,
      STATUS_LAST   = 2'd2
   } status_type;

   typedef enum logic {
      CSR_LOG_SCALE   = 1'b0,
      CSR_BASE_ENERGY = 1'b1
   } csr_index_type;

   // normalized mantissa and exponent of a raw word
   typedef struct packed {
      logic [P_W-1:0]    p;
      logic [MANT_W-1:0] m;
   } norm_type;

   // find the leading one and shift it to bit 31; zero is read as one
   function automatic norm_type log_normalize(input logic [ENERGY_W-1:0] x);
      logic [ENERGY_W-1:0] xx;
      logic [P_W-1:0]      p;
      norm_type            r;
      xx = (x == '0) ? ENERGY_W'(1) : x;
      p  = '0;
      for (int i = 0; i < ENERGY_W; i++) begin
         if (xx[i]) p = P_W'(i);
      end
      r.p = p;
      r.m = xx << (P_W'(MANT_W - 1) - p);
      return r;
   endfunction

   // one fraction bit of log2: square, renormalize, bit in the msb
   function automatic logic [MANT_W:0] log_square_step(input logic [MANT_W-1:0] m);
      logic [2*MANT_W-1:0] sq;
      logic [MANT_W:0]     t;
      sq = m * m;
      t  = sq[2*MANT_W-1:MANT_W-1];
      return t[MANT_W] ? {1'b1, t[MANT_W:1]} : {1'b0, t[MANT_W-1:0]};
   endfunction

endpackage

// ===== hw/rtl/ltcs_req_if.sv =====
// ----------------------------------------------------------------------------
// ltcs_req_if
// Request channel: table load or cross-section lookup.
// ----------------------------------------------------------------------------
interface ltcs_req_if
   import ltcs_pkg::*;
   ;
   logic                      valid;
   logic                      ready;
   logic                      action;
   logic [IDX_W-1:0]          entry_index;
   logic signed [VALUE_W-1:0] entry_value;
   logic [ENERGY_W-1:0]       energy;

   modport source (output valid, action, entry_index, entry_value, energy, input ready);
   modport sink   (input valid, action, entry_index, entry_value, energy, output ready);
endinterface

// ===== hw/rtl/ltcs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ltcs_rsp_if
// Response channel: clamped cross section and status.
// ----------------------------------------------------------------------------
interface ltcs_rsp_if
   import ltcs_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [XS_W-1:0]     cross_section;
   logic [STATUS_W-1:0] status;

   modport source (output valid, cross_section, status, input ready);
   modport sink   (input valid, cross_section, status, output ready);
endinterface

// ===== hw/rtl/ltcs_ram.sv =====
// ----------------------------------------------------------------------------
// ltcs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ltcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
   end

   // registered read, held while re is low
   always_ff @(posedge clock) begin
      if (re) rdata <= mem[raddr];
   end

endmodule

// ===== hw/rtl/ltcs_base_log.sv =====
// ----------------------------------------------------------------------------
// ltcs_base_log
// Iterative log2 of the base energy register, one fraction bit per cycle.
// Runs after reset and after each base energy write.
// ----------------------------------------------------------------------------
module ltcs_base_log
   import ltcs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [ENERGY_W-1:0] base_energy,
   output logic                ready,
   output logic [LOG_W-1:0]    base_log
);

   typedef enum logic [1:0] {
      IDLE,
      NORM,
      SQUARE
   } state_type;

   state_type              state_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [MANT_W-1:0]      m_ff;
   logic [P_W-1:0]         p_ff;
   logic [LOG_FRAC_BITS-1:0] f_ff;
   norm_type               norm;
   logic [MANT_W:0]        step;

   assign norm = log_normalize(base_energy);
   assign step = log_square_step(m_ff);

   // sequencer: normalize once, then square for each fraction bit
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= NORM;
         count_ff <= '0;
      end else if (start) begin
         // a new base energy restarts the computation from any state
         state_ff <= NORM;
      end else begin
         case (state_ff)
            IDLE: begin
               state_ff <= IDLE;
            end
            NORM: begin
               p_ff     <= norm.p;
               m_ff     <= norm.m;
               f_ff     <= '0;
               count_ff <= '0;
               state_ff <= SQUARE;
            end
            SQUARE: begin
               m_ff <= step[MANT_W-1:0];
               f_ff <= {f_ff[LOG_FRAC_BITS-2:0], step[MANT_W]};
               if (count_ff == CNT_W'(LOG_FRAC_BITS - 1)) begin
                  state_ff <= IDLE;
               end else begin
                  count_ff <= count_ff + CNT_W'(1);
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign ready    = (state_ff == IDLE);
   assign base_log = {p_ff, f_ff};

endmodule

// ===== hw/rtl/log_table_cross_section_lookup.sv =====
// ----------------------------------------------------------------------------
// log_table_cross_section_lookup
// Cross-section lookup from a table spaced evenly in log energy, with
// linear interpolation between neighboring entries.
//
//   channel  dir  handshake        payload
//   req_chan in   valid/ready      action, entry_index, entry_value, energy
//   rsp_chan out  valid/ready      cross_section, status
//   csr_*    in   csr_we           csr_index, csr_wdata
//
// One request per cycle unless a stalled response or the base log2 holds
// ready low; a lookup runs through the 24 squaring stages of the log2 pipeline.
// Loads write the table at the read stage, so lookups see loads in order.
// After reset and after a base energy write, req ready stays low while
// the base log2 is normalized and then computed one bit per cycle.
// A stalled response freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module log_table_cross_section_lookup
   import ltcs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   ltcs_req_if.sink              req_chan,
   ltcs_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int NSQ = LOG_FRAC_BITS;

   typedef struct packed {
      logic                      action;
      logic [IDX_W-1:0]          entry_index;
      logic signed [VALUE_W-1:0] entry_value;
      logic [P_W-1:0]            p;
      logic                      zero;
   } carry_type;

   // configuration
   logic [SCALE_W-1:0]  log_scale_ff;
   logic [ENERGY_W-1:0] base_energy_ff;
   logic                base_ready;
   logic [LOG_W-1:0]    base_log;

   // stall control
   logic adv;

   // input stage
   logic                in_v_ff;
   carry_type           in_c_ff;
   logic [ENERGY_W-1:0] in_energy_ff;
   norm_type            in_norm;

   // squaring stages
   logic [NSQ:0]             sq_v_ff;
   carry_type                sq_c_ff [NSQ+1];
   logic [MANT_W-1:0]        sq_m_ff [NSQ+1];
   logic [LOG_FRAC_BITS-1:0] sq_f_ff [NSQ+1];

   // difference, ln and scale stages
   logic            df_v_ff;
   carry_type       df_c_ff;
   logic [D_W-1:0]  df_d_ff;
   logic            ln_v_ff;
   carry_type       ln_c_ff;
   logic            ln_below_ff;
   logic [LN_W-1:0] ln_r_ff;
   logic [LN_W+31:0] ln_prod;
   logic            sc_v_ff;
   carry_type       sc_c_ff;
   logic            sc_below_ff;
   logic [S_W-1:0]  sc_s_ff;
   logic [LN_W+SCALE_W-1:0] sc_prod;

   // table read
   logic [L_W-1:0]    sc_l;
   logic              sc_last;
   logic [ADDR_W-1:0] addr_a;
   logic [ADDR_W-1:0] addr_b;
   logic              tbl_we;
   logic [VALUE_W-1:0] rdata_a;
   logic [VALUE_W-1:0] rdata_b;
   logic              rd_v_ff;
   logic              rd_below_ff;
   logic              rd_last_ff;
   logic [FRAC_W-1:0] rd_frac_ff;

   // interpolation stages
   logic                      ip_v_ff;
   logic                      ip_below_ff;
   logic                      ip_last_ff;
   logic [FRAC_W-1:0]         ip_frac_ff;
   logic signed [VALUE_W-1:0] ip_a_ff;
   logic signed [VALUE_W:0]   ip_diff_ff;
   logic                      mp_v_ff;
   logic                      mp_below_ff;
   logic                      mp_last_ff;
   logic signed [VALUE_W-1:0] mp_a_ff;
   logic signed [VALUE_W+FRAC_W+1:0] mp_prod_ff;
   logic signed [VALUE_W+FRAC_W+1:0] ip_prod;
   logic signed [VALUE_W+2:0] mp_sum;
   logic [XS_W-1:0]           out_xs;
   status_type                out_status;

   // output register
   logic              rsp_v_ff;
   logic [XS_W-1:0]   rsp_xs_ff;
   status_type        rsp_status_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         log_scale_ff   <= LOG_SCALE_RESET;
         base_energy_ff <= BASE_ENERGY_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_LOG_SCALE:   log_scale_ff   <= csr_wdata[SCALE_W-1:0];
            CSR_BASE_ENERGY: base_energy_ff <= csr_wdata[ENERGY_W-1:0];
            default: ;
         endcase
      end
   end

   // log2 of the base energy, recomputed after each change
   ltcs_base_log u_base_log (
      .clock       (clock),
      .reset       (reset),
      .start       (csr_we && (csr_index == CSR_BASE_ENERGY)),
      .base_energy (base_energy_ff),
      .ready       (base_ready),
      .base_log    (base_log)
   );

   // whole pipeline moves unless the output holds an unaccepted response
   assign adv            = !rsp_v_ff || rsp_chan.ready;
   assign req_chan.ready = adv && base_ready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (adv) begin
         in_v_ff                 <= req_chan.valid && base_ready;
         in_c_ff.action          <= req_chan.action;
         in_c_ff.entry_index     <= req_chan.entry_index;
         in_c_ff.entry_value     <= req_chan.entry_value;
         in_c_ff.p               <= '0;
         in_c_ff.zero            <= (req_chan.energy == '0);
         in_energy_ff            <= req_chan.energy;
      end
   end

   // normalize energy to a Q1.31 mantissa
   assign in_norm = log_normalize(in_energy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_v_ff[0]   <= in_v_ff;
         sq_c_ff[0]   <= '{action: in_c_ff.action, entry_index: in_c_ff.entry_index,
                           entry_value: in_c_ff.entry_value, p: in_norm.p,
                           zero: in_c_ff.zero};
         sq_m_ff[0]   <= in_norm.m;
         sq_f_ff[0]   <= '0;
      end
   end

   // one squaring stage per fraction bit of log2
   for (genvar k = 1; k <= NSQ; k++) begin : g_sq
      logic [MANT_W:0] step;
      assign step = log_square_step(sq_m_ff[k-1]);

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k] <= 1'b0;
         end else if (adv) begin
            sq_v_ff[k] <= sq_v_ff[k-1];
            sq_c_ff[k] <= sq_c_ff[k-1];
            sq_m_ff[k] <= step[MANT_W-1:0];
            sq_f_ff[k] <= {sq_f_ff[k-1][LOG_FRAC_BITS-2:0], step[MANT_W]};
         end
      end
   end

   // log difference, ln conversion and scaling to a table position
   assign ln_prod = df_d_ff[LOG_W-1:0] * LN2_Q32;
   assign sc_prod = ln_r_ff * log_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         df_v_ff <= 1'b0;
         ln_v_ff <= 1'b0;
         sc_v_ff <= 1'b0;
      end else if (adv) begin
         df_v_ff     <= sq_v_ff[NSQ];
         df_c_ff     <= sq_c_ff[NSQ];
         df_d_ff     <= {1'b0, sq_c_ff[NSQ].p, sq_f_ff[NSQ]} - {1'b0, base_log};
         ln_v_ff     <= df_v_ff;
         ln_c_ff     <= df_c_ff;
         ln_below_ff <= df_c_ff.zero || df_d_ff[D_W-1];
         ln_r_ff     <= ln_prod[LN_W+31:32];
         sc_v_ff     <= ln_v_ff;
         sc_c_ff     <= ln_c_ff;
         sc_below_ff <= ln_below_ff;
         sc_s_ff     <= sc_prod[LN_W+SCALE_W-1:SCALE_W];
      end
   end

   // table addresses; loads write here so they stay in request order
   assign sc_l    = sc_s_ff[S_W-1:FRAC_W];
   assign sc_last = (sc_l >= L_W'(TABLE_ENTRIES - 1));
   assign addr_a  = sc_last ? ADDR_W'(TABLE_ENTRIES - 1) : sc_l[ADDR_W-1:0];
   assign addr_b  = sc_last ? ADDR_W'(TABLE_ENTRIES - 1)
                            : sc_l[ADDR_W-1:0] + ADDR_W'(1);
   assign tbl_we  = adv && sc_v_ff && (sc_c_ff.action == ACTION_LOAD)
                    && ({1'b0, sc_c_ff.entry_index} < (IDX_W+1)'(TABLE_ENTRIES));

   ltcs_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_ENTRIES)) u_table_a (
      .clock (clock),
      .we    (tbl_we),
      .waddr (sc_c_ff.entry_index[ADDR_W-1:0]),
      .wdata (sc_c_ff.entry_value),
      .re    (adv),
      .raddr (addr_a),
      .rdata (rdata_a)
   );

   ltcs_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_ENTRIES)) u_table_b (
      .clock (clock),
      .we    (tbl_we),
      .waddr (sc_c_ff.entry_index[ADDR_W-1:0]),
      .wdata (sc_c_ff.entry_value),
      .re    (adv),
      .raddr (addr_b),
      .rdata (rdata_b)
   );

   // lookups continue past the read stage, loads end here
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
      end else if (adv) begin
         rd_v_ff     <= sc_v_ff && (sc_c_ff.action == ACTION_LOOKUP);
         rd_below_ff <= sc_below_ff;
         rd_last_ff  <= sc_last;
         rd_frac_ff  <= sc_s_ff[FRAC_W-1:0];
      end
   end

   // neighbor difference, then difference times fraction
   assign ip_prod = ip_diff_ff * $signed({1'b0, ip_frac_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         ip_v_ff <= 1'b0;
         mp_v_ff <= 1'b0;
      end else if (adv) begin
         ip_v_ff     <= rd_v_ff;
         ip_below_ff <= rd_below_ff;
         ip_last_ff  <= rd_last_ff;
         ip_frac_ff  <= rd_frac_ff;
         ip_a_ff     <= $signed(rdata_a);
         ip_diff_ff  <= $signed({rdata_b[VALUE_W-1], rdata_b})
                        - $signed({rdata_a[VALUE_W-1], rdata_a});
         mp_v_ff     <= ip_v_ff;
         mp_below_ff <= ip_below_ff;
         mp_last_ff  <= ip_last_ff;
         mp_a_ff     <= ip_a_ff;
         mp_prod_ff  <= ip_prod;
      end
   end

   // lower entry plus floor of the scaled step (last entry alone), clamped at zero
   always_comb begin
      mp_sum = (VALUE_W+3)'(mp_a_ff);
      if (!mp_last_ff) begin
         mp_sum = mp_sum + (VALUE_W+3)'(mp_prod_ff >>> FRAC_W);
      end
      out_xs = (mp_sum > 0) ? mp_sum[XS_W-1:0] : '0;
      if (mp_below_ff) begin
         out_xs     = '0;
         out_status = STATUS_BELOW;
      end else if (mp_last_ff) begin
         out_status = STATUS_LAST;
      end else begin
         out_status = STATUS_INTERP;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         rsp_v_ff      <= mp_v_ff;
         rsp_xs_ff     <= out_xs;
         rsp_status_ff <= out_status;
      end
   end

   assign rsp_chan.valid         = rsp_v_ff;
   assign rsp_chan.cross_section = rsp_xs_ff;
   assign rsp_chan.status        = rsp_status_ff;

   // no request enters while the base log2 is being recomputed
   a_no_req_while_base_busy : assert property (@(posedge clock) disable iff (reset)
      !base_ready |-> !req_chan.ready)
      else $error("request channel ready while base log2 busy");

   // a stall freezes the stages around the table read
   a_stall_holds_pipe : assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(sc_v_ff) && $stable(rd_v_ff) && $stable(mp_v_ff))
      else $error("pipeline moved during a stall");

   // below-table responses always carry a zero cross section
   a_below_is_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && (rsp_status_ff == STATUS_BELOW) |-> (rsp_xs_ff == '0))
      else $error("below-table response with nonzero cross section");

   // status is one of the three defined codes
   a_status_legal : assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff |-> (rsp_status_ff == STATUS_INTERP) || (rsp_status_ff == STATUS_BELOW)
                   || (rsp_status_ff == STATUS_LAST))
      else $error("undefined response status");

   // a table write only happens for a load
   a_write_only_on_load : assert property (@(posedge clock) disable iff (reset)
      tbl_we |-> sc_v_ff && (sc_c_ff.action == ACTION_LOAD) && !rd_v_ff ||
                 tbl_we && sc_v_ff && (sc_c_ff.action == ACTION_LOAD))
      else $error("table written by a non-load request");

endmodule

// ===== bench/ltcs_lookup_checker.sv =====
// ----------------------------------------------------------------------------
// ltcs_lookup_checker
// Watches the request, response and register ports of the log-spaced
// cross-section lookup. It keeps its own copy of the table and registers,
// predicts each lookup in fixed point and compares the responses in order.
// ----------------------------------------------------------------------------
module ltcs_lookup_checker
   import ltcs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   ltcs_req_if                   req_chan,
   ltcs_rsp_if                   rsp_chan,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatches,
   output int                    pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [XS_W-1:0] cross_section;
      status_type      status;
   } xs_result_type;

   logic [SCALE_W-1:0]        log_scale_q;
   logic [ENERGY_W-1:0]       base_energy_q;
   logic signed [VALUE_W-1:0] xs_table [TABLE_ENTRIES];
   xs_result_type             lookup_q [$];
   xs_result_type             want;

   task automatic report_mismatch(input string what, input longint got, input longint exp_val);
      $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, exp_val);
      mismatches++;
   endtask

   // log2 of a raw word in Q5.24, one fraction bit per squaring
   function automatic logic [LOG_W-1:0] fixed_log2(input logic [ENERGY_W-1:0] x);
      logic [ENERGY_W-1:0]      v;
      logic [63:0]              m;
      logic [P_W-1:0]           lead;
      logic [LOG_FRAC_BITS-1:0] frac;
      v = (x == '0) ? ENERGY_W'(1) : x;
      lead = '0;
      for (int i = 0; i < ENERGY_W; i++) begin
         if (v[i]) lead = P_W'(i);
      end
      m = 64'(v) << (31 - lead);
      frac = '0;
      repeat (LOG_FRAC_BITS) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            m = m >> 1;
            frac[0] = 1'b1;
         end
      end
      return {lead, frac};
   endfunction

   // table position from the log ratio, then interpolate or take the last entry
   function automatic xs_result_type predict_lookup(input logic [ENERGY_W-1:0] energy);
      xs_result_type r;
      longint        diff;
      longint        a;
      longint        b;
      longint        value;
      logic [63:0]   ln_ratio;
      logic [63:0]   pos;
      logic [63:0]   seg;
      logic [15:0]   frac;
      r.status = STATUS_BELOW;
      r.cross_section = '0;
      if (energy == '0) return r;
      diff = longint'(fixed_log2(energy)) - longint'(fixed_log2(base_energy_q));
      if (diff < 0) return r;
      ln_ratio = (64'(diff) * 64'(LN2_Q32)) >> 32;
      pos = (ln_ratio * 64'(log_scale_q)) >> 24;
      seg = pos >> FRAC_W;
      frac = pos[15:0];
      if (seg >= TABLE_ENTRIES - 1) begin
         value = xs_table[TABLE_ENTRIES-1];
         r.status = STATUS_LAST;
      end else begin
         a = xs_table[seg];
         b = xs_table[seg+1];
         // arithmetic shift rounds toward minus infinity
         value = a + (((b - a) * longint'({1'b0, frac})) >>> 16);
         r.status = STATUS_INTERP;
      end
      if (value > 0) r.cross_section = value[XS_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         log_scale_q = LOG_SCALE_RESET;
         base_energy_q = BASE_ENERGY_RESET;
         lookup_q.delete();
      end else begin
         // register writes
         if (csr_we) begin
            if (csr_index == CSR_LOG_SCALE) log_scale_q = csr_wdata[SCALE_W-1:0];
            else base_energy_q = csr_wdata;
         end
         // compare each response with the oldest pending lookup
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (lookup_q.size() == 0) begin
               report_mismatch("unexpected response cross_section",
                               longint'(rsp_chan.cross_section), 0);
            end else begin
               want = lookup_q.pop_front();
               if (rsp_chan.cross_section !== want.cross_section)
                  report_mismatch("cross_section", longint'(rsp_chan.cross_section),
                                  longint'(want.cross_section));
               if (rsp_chan.status !== want.status)
                  report_mismatch("status", longint'(rsp_chan.status), longint'(want.status));
            end
         end
         // accepted request: lookup is predicted, load updates the table copy
         if (req_chan.valid && req_chan.ready) begin
            if (req_chan.action == ACTION_LOOKUP)
               lookup_q.push_back(predict_lookup(req_chan.energy));
            else if (req_chan.entry_index < TABLE_ENTRIES)
               xs_table[req_chan.entry_index] = req_chan.entry_value;
         end
      end
      pending_results <= lookup_q.size();
   end

endmodule

// ===== bench/tb_log_table_cross_section_lookup.sv =====
// ----------------------------------------------------------------------------
// tb_log_table_cross_section_lookup
// Drives loads and lookups into the log-spaced cross-section lookup under
// random gaps and response stalls, across several register settings, and
// reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_log_table_cross_section_lookup
   import ltcs_pkg::*;
   ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES     = 40;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int RANDOM_PER_PHASE = 87;
   localparam int HOLD_OFF_CYCLES  = 150;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic                  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    mismatches;
   int                    pending_results;
   int                    cycle_count;
   int                    sent_count;
   bit                    sender_pauses;
   logic [ENERGY_W-1:0]   cur_base;

   ltcs_req_if lookup_req ();
   ltcs_rsp_if lookup_rsp ();

   always #5 clock = ~clock;

   log_table_cross_section_lookup uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (lookup_req),
      .rsp_chan  (lookup_rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ltcs_lookup_checker lookup_checker (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (lookup_req),
      .rsp_chan        (lookup_rsp),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .pending_results (pending_results)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // one request, with an optional gap before it
   task automatic send_request(input action_type act, input logic [IDX_W-1:0] idx,
                               input logic [VALUE_W-1:0] value,
                               input logic [ENERGY_W-1:0] energy);
      int gap;
      if (sent_count % 40 == 0) sender_pauses = !sender_pauses;
      gap = sender_pauses ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         lookup_req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      lookup_req.valid       <= 1'b1;
      lookup_req.action      <= act;
      lookup_req.entry_index <= idx;
      lookup_req.entry_value <= value;
      lookup_req.energy      <= energy;
      do @(posedge clock); while (!(lookup_req.valid && lookup_req.ready));
      sent_count++;
   endtask

   task automatic send_load(input logic [IDX_W-1:0] idx, input logic [VALUE_W-1:0] value);
      send_request(ACTION_LOAD, idx, value, $urandom);
   endtask

   task automatic send_lookup(input logic [ENERGY_W-1:0] energy);
      send_request(ACTION_LOOKUP, IDX_W'($urandom), VALUE_W'($urandom), energy);
   endtask

   // stop offering, wait for every response, then let in-flight loads settle
   task automatic drain();
      lookup_req.valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // both registers, written back to back while the block is idle
   task automatic set_config(input logic [SCALE_W-1:0] scale, input logic [ENERGY_W-1:0] base);
      drain();
      csr_we    <= 1'b1;
      csr_index <= CSR_LOG_SCALE;
      csr_wdata <= CSR_DATA_W'(scale);
      @(posedge clock);
      csr_index <= CSR_BASE_ENERGY;
      csr_wdata <= base;
      @(posedge clock);
      csr_we <= 1'b0;
      cur_base  = base;
   endtask

   // half of the energies spread over the table span above the base energy
   function automatic logic [ENERGY_W-1:0] pick_energy();
      logic [63:0]         wide;
      logic [ENERGY_W-1:0] mant;
      case ($urandom_range(0, 15))
         0: return '0;
         1: return '1;
         2: return cur_base - (cur_base >> $urandom_range(1, 31));
         3, 4, 5, 6, 7, 8, 9, 10: begin
            mant = 32'h8000_0000 | $urandom;
            wide = ((64'(cur_base) * 64'(mant)) >> 31) << $urandom_range(0, 13);
            return (wide > 64'hFFFF_FFFF) ? '1 : wide[ENERGY_W-1:0];
         end
         default: return $urandom >> $urandom_range(0, 31);
      endcase
   endfunction

   function automatic logic [SCALE_W-1:0] pick_scale();
      logic [SCALE_W-1:0] v;
      v = SCALE_W'($urandom) >> $urandom_range(0, SCALE_W - 1);
      return (v == '0) ? SCALE_W'(1) : v;
   endfunction

   function automatic logic [ENERGY_W-1:0] pick_base();
      logic [ENERGY_W-1:0] v;
      v = $urandom >> $urandom_range(0, ENERGY_W - 1);
      return (v == '0) ? ENERGY_W'(1) : v;
   endfunction

   task automatic random_item();
      if ($urandom_range(0, 3) == 0)
         send_load(IDX_W'($urandom_range(0, 127)), VALUE_W'($urandom));
      else send_lookup(pick_energy());
   endtask

   // response side: random stalls, calm stretches and two long hold-offs
   initial begin : response_side
      int  wait_cycles;
      int  taken;
      bit  pauses;
      lookup_rsp.ready <= 1'b0;
      taken  = 0;
      pauses = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken % 50 == 0) pauses = !pauses;
         if (taken == 40 || taken == 200) wait_cycles = HOLD_OFF_CYCLES;
         else wait_cycles = pauses ? $urandom_range(0, 11) : 0;
         if (wait_cycles > 0) begin
            lookup_rsp.ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         lookup_rsp.ready <= 1'b1;
         do @(posedge clock); while (!(lookup_rsp.valid && lookup_rsp.ready));
         taken++;
      end
   end

   initial begin : stimulus
      logic [SCALE_W-1:0]  scale_plan [4];
      logic [ENERGY_W-1:0] base_plan [4];
      lookup_req.valid       <= 1'b0;
      lookup_req.action      <= ACTION_LOAD;
      lookup_req.entry_index <= '0;
      lookup_req.entry_value <= '0;
      lookup_req.energy      <= '0;
      csr_we                 <= 1'b0;
      csr_index              <= CSR_LOG_SCALE;
      csr_wdata              <= '0;
      cur_base  = BASE_ENERGY_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // fill the whole table so no lookup reads an unwritten entry
      for (int i = 0; i < TABLE_ENTRIES; i++) send_load(IDX_W'(i), VALUE_W'($urandom));

      // directed: value extremes, ignored loads, zero and below-base energy,
      // exact base, last entry and clamping of negative results
      send_load(IDX_W'(0), 24'h7FFFFF);
      send_load(IDX_W'(1), 24'h800000);
      send_load(IDX_W'(127), 24'h123456);
      send_load(IDX_W'(TABLE_ENTRIES), 24'h000001);
      send_lookup('0);
      send_lookup(32'd1);
      send_lookup(BASE_ENERGY_RESET - 1);
      send_lookup(BASE_ENERGY_RESET);
      send_lookup(BASE_ENERGY_RESET + 57);
      send_lookup('1);
      send_load(IDX_W'(TABLE_ENTRIES - 1), 24'hFFFFFF);
      send_lookup('1);
      send_load(IDX_W'(TABLE_ENTRIES - 1), 24'h7FFFFF);
      send_lookup(32'h8000_0000);
      send_lookup(32'd65536000);
      send_lookup(32'd65536);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) random_item();

      // further register settings, extremes first
      scale_plan = '{24'hFFFFFF, 24'd1, pick_scale(), pick_scale()};
      base_plan  = '{32'd1, 32'hFFFF_FFFF, pick_base(), pick_base()};
      for (int p = 0; p < 4; p++) begin
         set_config(scale_plan[p], base_plan[p]);
         for (int n = 0; n < RANDOM_PER_PHASE; n++) random_item();
      end

      drain();
      if (mismatches == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
